// ===== hw/rtl/lfu_pkg.sv =====
// shared types and constants for the lfu cache with lru tie-break
package lfu_pkg;

  localparam int unsigned CAP_DEFAULT    = 16;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned VAL_W          = 31;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned STAMP_W        = 48;
  localparam int unsigned CAPACITY_W     = 5;
  localparam int unsigned RDATA_W        = 32;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(16);
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = {COUNT_W{1'b1}};

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } lfu_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [RDATA_W-1:0] read_value;
    logic                      evicted;
    logic [KEY_W-1:0]          evicted_key;
  } lfu_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

  typedef struct packed {
    logic       found;
    logic       have_victim;
    lfu_entry_t hit_entry;
    lfu_entry_t victim_entry;
  } lfu_scan_t;

endpackage

// ===== hw/rtl/lfu_mem.sv =====
// entry memory: one write port, one read port with registered read data
module lfu_mem
  import lfu_pkg::*;
#(
  parameter int unsigned Depth = CAP_DEFAULT,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  lfu_entry_t       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output lfu_entry_t       rdata_o
);

  lfu_entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/lfu_scan.sv =====
// scan accumulator: first key match and least-used, oldest victim
module lfu_scan
  import lfu_pkg::*;
#(
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             valid_i,
  input  logic [AddrW-1:0] idx_i,
  input  lfu_entry_t       entry_i,
  input  logic [KEY_W-1:0] key_i,
  output lfu_scan_t        scan_o,
  output logic [AddrW-1:0] slot_o,
  output logic [AddrW-1:0] victim_o
);

  logic             found_q;
  logic             have_victim_q;
  lfu_entry_t       hit_entry_q;
  lfu_entry_t       victim_entry_q;
  logic [AddrW-1:0] slot_q;
  logic [AddrW-1:0] victim_q;
  logic             take_hit;
  logic             take_victim;

  assign take_hit = valid_i && !found_q && (entry_i.key == key_i);
  assign take_victim = valid_i && (!have_victim_q ||
                       (entry_i.count < victim_entry_q.count) ||
                       ((entry_i.count == victim_entry_q.count) &&
                        (entry_i.stamp < victim_entry_q.stamp)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q       <= 1'b0;
      have_victim_q <= 1'b0;
    end else if (clear_i) begin
      found_q       <= 1'b0;
      have_victim_q <= 1'b0;
    end else begin
      if (take_hit) begin
        found_q <= 1'b1;
      end
      if (take_victim) begin
        have_victim_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_entry_q <= entry_i;
      slot_q      <= idx_i;
    end
    if (take_victim) begin
      victim_entry_q <= entry_i;
      victim_q       <= idx_i;
    end
  end

  assign scan_o   = '{found: found_q, have_victim: have_victim_q,
                      hit_entry: hit_entry_q, victim_entry: victim_entry_q};
  assign slot_o   = slot_q;
  assign victim_o = victim_q;

endmodule

// ===== hw/rtl/lfu_cache_lru_tiebreak.sv =====
// top level of the lfu key-value cache with lru tie-break
// A command is taken when start is high and busy is low; busy then stays high
// while the single read port of the entry memory is walked one entry per cycle
// over the held entries (at most CAP of them), while the last read data
// returns and while the chosen entry is written back. The result is shown on
// rsp_o with res_valid_o high for exactly one cycle, the first cycle with busy
// low again, and cannot be held off by the receiver. A new command may be given
// in that same cycle.
// Entries are filled in slot order and never freed, so no clearing pass is
// needed after reset.
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int unsigned CAP = CAP_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lfu_req_t              req_i,
  output logic                  res_valid_o,
  output lfu_rsp_t              rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CAPACITY_W-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned FillW = $clog2(CAP + 1);
  localparam int unsigned EffW  = (FillW > CAPACITY_W) ? FillW : CAPACITY_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e                 state_q;
  lfu_req_t               req_q;
  logic [FillW-1:0]       issue_q;
  logic                   rvalid_q;
  logic [AddrW-1:0]       ridx_q;
  logic [FillW-1:0]       fill_q;
  logic [FillW-1:0]       fill_d;
  logic [STAMP_W-1:0]     stamp_q;
  logic [CAPACITY_W-1:0]  capacity_q;
  lfu_rsp_t               rsp_q;
  lfu_rsp_t               rsp_d;
  logic                   res_valid_q;

  logic                   accept;
  logic                   issue;
  logic [EffW-1:0]        eff;
  logic [EffW-1:0]        cap_ext;
  logic [EffW-1:0]        cap_lim;
  logic                   has_room;

  logic                   we;
  logic [AddrW-1:0]       waddr;
  lfu_entry_t             wdata;
  lfu_entry_t             rdata;
  lfu_scan_t              scan;
  logic [AddrW-1:0]       slot;
  logic [AddrW-1:0]       victim;
  logic [COUNT_W-1:0]     count_inc;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign issue  = (state_q == ST_SCAN) && (issue_q != fill_q);

  assign cap_ext  = EffW'(capacity_q);
  assign cap_lim  = EffW'(CAP);
  assign eff      = (cap_ext < cap_lim) ? cap_ext : cap_lim;
  assign has_room = (EffW'(fill_q) < eff);

  assign count_inc = (scan.hit_entry.count == COUNT_MAX) ? scan.hit_entry.count
                                                        : scan.hit_entry.count + 1'b1;

  lfu_mem #(
    .Depth (CAP),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (issue_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  lfu_scan #(
    .AddrW (AddrW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (accept),
    .valid_i  (rvalid_q),
    .idx_i    (ridx_q),
    .entry_i  (rdata),
    .key_i    (req_q.lookup_key),
    .scan_o   (scan),
    .slot_o   (slot),
    .victim_o (victim)
  );

  // commit decision: write-back entry, fill update and result
  always_comb begin
    we                = 1'b0;
    waddr             = slot;
    wdata.key         = req_q.lookup_key;
    wdata.value       = req_q.write_value;
    wdata.count       = count_inc;
    wdata.stamp       = stamp_q;
    fill_d            = fill_q;
    rsp_d.hit         = scan.found;
    rsp_d.read_value  = '1;
    rsp_d.evicted     = 1'b0;
    rsp_d.evicted_key = '0;
    if (state_q == ST_COMMIT) begin
      if (req_q.func == FUNC_GET) begin
        if (scan.found) begin
          we               = 1'b1;
          wdata.value      = scan.hit_entry.value;
          rsp_d.read_value = {1'b0, scan.hit_entry.value};
        end
      end else if (eff != '0) begin
        we = 1'b1;
        if (!scan.found) begin
          wdata.count = COUNT_W'(1);
          if (has_room) begin
            waddr  = fill_q[AddrW-1:0];
            fill_d = fill_q + 1'b1;
          end else begin
            waddr             = victim;
            rsp_d.evicted     = 1'b1;
            rsp_d.evicted_key = scan.victim_entry.key;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      rvalid_q    <= 1'b0;
      fill_q      <= '0;
      stamp_q     <= '0;
      capacity_q  <= CAPACITY_RESET;
      res_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      rvalid_q    <= issue;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            issue_q <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            issue_q <= issue_q + 1'b1;
          end else begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          fill_q      <= fill_d;
          res_valid_q <= 1'b1;
          rsp_q       <= rsp_d;
          if (we) begin
            stamp_q <= stamp_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (issue) begin
      ridx_q <= issue_q[AddrW-1:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== dv/testbench.sv =====
// testbench for the lfu key-value cache with lru tie-break
`timescale 1ns / 1ps

module testbench;
  import lfu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOT_GETS    = 20;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  lfu_req_t              req_i       = '0;
  logic                  res_valid_o;
  lfu_rsp_t              rsp_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CAPACITY_W-1:0] cfg_wdata_i = '0;

  lfu_cache_lru_tiebreak u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // cache mirror
  logic                  slot_used [CAP_DEFAULT];
  lfu_entry_t            slot_data [CAP_DEFAULT];
  logic [STAMP_W-1:0]    stamp_now;
  int unsigned           slots_held;
  logic [CAPACITY_W-1:0] capacity_reg;

  lfu_rsp_t    awaited_rsp[$];
  logic [31:0] key_pool[20];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void touch_slot(int idx);
    if (slot_data[idx].count != COUNT_MAX) slot_data[idx].count++;
    slot_data[idx].stamp = stamp_now;
    stamp_now++;
  endfunction

  function automatic lfu_rsp_t cache_access(lfu_req_t r);
    int          hit_idx;
    int          victim_idx;
    int          free_idx;
    int          tgt;
    bit          found;
    bit          have_victim;
    bit          have_free;
    int unsigned eff;
    lfu_rsp_t    rsp;
    hit_idx     = 0;
    victim_idx  = 0;
    free_idx    = 0;
    found       = 1'b0;
    have_victim = 1'b0;
    have_free   = 1'b0;
    eff = (capacity_reg < CAP_DEFAULT) ? capacity_reg : CAP_DEFAULT;
    for (int i = 0; i < CAP_DEFAULT; i++) begin
      if (slot_used[i]) begin
        if (!found && slot_data[i].key == r.lookup_key) begin
          found   = 1'b1;
          hit_idx = i;
        end
        if (!have_victim || slot_data[i].count < slot_data[victim_idx].count ||
            (slot_data[i].count == slot_data[victim_idx].count &&
             slot_data[i].stamp < slot_data[victim_idx].stamp)) begin
          have_victim = 1'b1;
          victim_idx  = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
    end
    rsp.hit         = found;
    rsp.read_value  = -1;
    rsp.evicted     = 1'b0;
    rsp.evicted_key = '0;
    if (r.func == FUNC_GET) begin
      if (found) begin
        rsp.read_value = {1'b0, slot_data[hit_idx].value};
        touch_slot(hit_idx);
      end
    end else if (eff != 0) begin
      if (found) begin
        slot_data[hit_idx].value = r.write_value;
        touch_slot(hit_idx);
      end else begin
        if (slots_held < eff && have_free) begin
          tgt = free_idx;
          slots_held++;
        end else if (have_victim) begin
          tgt             = victim_idx;
          rsp.evicted     = 1'b1;
          rsp.evicted_key = slot_data[victim_idx].key;
        end else begin
          tgt = free_idx;
          slots_held++;
        end
        slot_used[tgt]       = 1'b1;
        slot_data[tgt].key   = r.lookup_key;
        slot_data[tgt].value = r.write_value;
        slot_data[tgt].count = '0;
        touch_slot(tgt);
      end
    end
    return rsp;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, rsp_o);
        errors++;
      end else begin
        lfu_rsp_t want;
        want = awaited_rsp.pop_front();
        check_field("hit", 32'(want.hit), 32'(rsp_o.hit));
        check_field("read_value", want.read_value, rsp_o.read_value);
        check_field("evicted", 32'(want.evicted), 32'(rsp_o.evicted));
        check_field("evicted_key", want.evicted_key, rsp_o.evicted_key);
      end
    end
  end

  task automatic send(input logic func, input logic [31:0] key, input logic [30:0] val);
    lfu_req_t cmd;
    cmd.func        = func;
    cmd.lookup_key  = key;
    cmd.write_value = val;
    start <= 1'b1;
    req_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    awaited_rsp.push_back(cache_access(cmd));
  endtask

  task automatic idle_gap(input bit quiet);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 50) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAPACITY_W-1:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg  = cap;
  endtask

  // heavily used entry outlives a more recent, less used one
  task automatic test_count_priority();
    set_capacity(2);
    send(FUNC_PUT, 32'h5A5A_0001, 31'd1);
    for (int i = 0; i < HOT_GETS; i++) send(FUNC_GET, 32'h5A5A_0001, 31'd0);
    send(FUNC_PUT, 32'h5A5A_0002, 31'd2);
    repeat (10) send(FUNC_GET, 32'h5A5A_0002, 31'd0);
    send(FUNC_GET, 32'h5A5A_0001, 31'd0);
    send(FUNC_PUT, 32'h5A5A_0003, 31'd3);
  endtask

  task automatic test_basic_ops();
    set_capacity(16);
    send(FUNC_GET, 32'h0000_0000, 31'h7FFF_FFFF);
    send(FUNC_PUT, 32'h0000_0000, 31'h0);
    send(FUNC_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send(FUNC_GET, 32'hFFFF_FFFF, 31'h0);
    send(FUNC_PUT, 32'h0000_0000, 31'h1234);
    send(FUNC_GET, 32'h0000_0000, 31'h0);
    send(FUNC_GET, 32'h8000_0000, 31'h0);
    send(FUNC_PUT, 32'h8000_0000, 31'h4000_0000);
  endtask

  task automatic test_capacity_zero();
    set_capacity(0);
    send(FUNC_PUT, 32'h0000_0005, 31'h55);
    send(FUNC_PUT, 32'h0000_0000, 31'h99);
    send(FUNC_GET, 32'h0000_0000, 31'h0);
    send(FUNC_GET, 32'h0000_0005, 31'h0);
  endtask

  // capacity below fill, equal counts resolved by age
  task automatic test_shrink_and_tie();
    set_capacity(2);
    send(FUNC_PUT, 32'h0000_0011, 31'h11);
    send(FUNC_PUT, 32'h0000_0022, 31'h22);
    send(FUNC_GET, 32'h0000_0022, 31'h0);
    send(FUNC_GET, 32'h0000_0022, 31'h0);
    send(FUNC_PUT, 32'h0000_0033, 31'h33);
  endtask

  task automatic test_capacity_above_max();
    set_capacity(31);
    send(FUNC_PUT, 32'h0000_0044, 31'h44);
    send(FUNC_PUT, 32'h0000_0045, 31'h45);
    send(FUNC_GET, 32'h0000_0044, 31'h0);
  endtask

  task automatic test_random_traffic();
    logic [CAPACITY_W-1:0] caps[8];
    logic [31:0]           key;
    logic                  func;
    bit                    quiet;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd0, 5'd8, 5'd16};
    caps[5] = CAPACITY_W'($urandom_range(0, 31));
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 20; i++) key_pool[i] = $urandom();
    for (int p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      quiet = (p % 3 == 1);
      for (int n = 0; n < 212; n++) begin
        func = ($urandom_range(0, 99) < 55) ? FUNC_PUT : FUNC_GET;
        if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, 19)];
        else key = $urandom();
        send(func, key, 31'($urandom()));
        if ($urandom_range(0, 99) == 0) drain();
        else idle_gap(quiet);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CAP_DEFAULT; i++) begin
      slot_used[i] = 1'b0;
      slot_data[i] = '0;
    end
    stamp_now    = '0;
    slots_held   = 0;
    capacity_reg = CAPACITY_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_count_priority();
    test_basic_ops();
    test_capacity_zero();
    test_shrink_and_tie();
    test_capacity_above_max();
    test_random_traffic();
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_mem.sv
hw/rtl/lfu_scan.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
dv/testbench.sv
